>>> rtl/rasb_pkg.sv
package rasb_pkg;

    localparam int DESC_REGS   = 4;
    localparam int LANE_BITS   = 8;
    localparam int LANES       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int DATA_W      = 32;
    localparam int SEQ_W       = 8;
    localparam int PAGE_W      = 8;
    localparam int OFFSET_W    = 8;
    localparam int SIZE_W      = 11;

    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_ZERO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_ONE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_TWO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_THREE   = 3'd5;

    localparam logic [2:0] RES_OK        = 3'd0;
    localparam logic [2:0] RES_MALFORMED = 3'd1;
    localparam logic [2:0] RES_SEQ       = 3'd2;
    localparam logic [2:0] RES_MODE      = 3'd3;
    localparam logic [2:0] RES_ADDR      = 3'd4;
    localparam logic [2:0] RES_PERM      = 3'd5;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_BULK  = 2'd2;

    localparam logic [1:0] PTYPE_WORD = 2'd1;
    localparam logic [1:0] PTYPE_BYTE = 2'd2;

    localparam logic [1:0] PERM_RO = 2'd0;
    localparam logic [1:0] PERM_WO = 2'd1;
    localparam logic [1:0] PERM_RW = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic                message_empty;
        logic                length_ok;
        logic                is_write;
        logic                bulk;
        logic                bulk_last;
        logic                multiword;
        logic [1:0]          req_mode;
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
        logic [SEQ_W-1:0]    seq_count;
        logic [DATA_W-1:0]   write_data;
    } t_req;

endpackage

>>> rtl/rasb_if.sv
interface rasb_req_if;
    logic                          valid;
    logic                          ready;
    logic                          message_empty;
    logic                          length_ok;
    logic                          is_write;
    logic                          bulk;
    logic                          bulk_last;
    logic                          multiword;
    logic [1:0]                    req_mode;
    logic [rasb_pkg::PAGE_W-1:0]   page;
    logic [rasb_pkg::OFFSET_W-1:0] offset;
    logic [rasb_pkg::SEQ_W-1:0]    seq_count;
    logic [rasb_pkg::DATA_W-1:0]   write_data;

    modport source (
        output valid, message_empty, length_ok, is_write, bulk, bulk_last, multiword,
               req_mode, page, offset, seq_count, write_data,
        input  ready
    );
    modport sink (
        input  valid, message_empty, length_ok, is_write, bulk, bulk_last, multiword,
               req_mode, page, offset, seq_count, write_data,
        output ready
    );
endinterface

interface rasb_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  response_kind;
    logic [2:0]                  result;
    logic [rasb_pkg::DATA_W-1:0] rd_word;
    logic [rasb_pkg::SEQ_W-1:0]  seq_number;

    modport source (
        output valid, response_kind, result, rd_word, seq_number,
        input  ready
    );
    modport sink (
        input  valid, response_kind, result, rd_word, seq_number,
        output ready
    );
endinterface

interface rasb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rasb_pkg::CFG_IDX_W-1:0]  index;
    logic [rasb_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> rtl/register_access_server_bulk.sv
// channel   direction  handshake      payload
// i_req     in         valid/ready    flags, req_mode, page, offset, seq_count, write_data
// o_rsp     out        valid/ready    response_kind, result, rd_word, seq_number
// i_cfg     in         valid/ready    index, data (always ready)
//
// The accept cycle issues the page memory read; in the execute state that follows,
// the request is checked, byte lanes merged and written back through the single port.
// After reset a clearing pass zeroes the memory, during which i_req.ready is low;
// configuration writes are taken throughout.
// A full output register that is not taken holds the execute state until it drains.
// Reset is synchronous, active low, and clears control state and configuration.
module register_access_server_bulk #(
    parameter int PAGE_SLOTS = 4,
    parameter int PAGE_WORDS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rasb_req_if.sink     i_req,
    rasb_rsp_if.source   o_rsp,
    rasb_cfg_if.sink     i_cfg
);
    import rasb_pkg::*;

    localparam int DEPTH = PAGE_SLOTS * PAGE_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    t_state r_state, n_state;
    t_req   r_req;
    logic [AW-1:0] r_addr;

    logic            r_clearing;
    logic [AW-1:0]   r_clr_addr;

    logic [1:0]            r_ctrl_mode;
    logic [2:0]            r_page_count;
    logic [CFG_DATA_W-1:0] r_desc [DESC_REGS];

    logic             r_in_bulk, n_in_bulk;
    logic [2:0]       r_bulk_error, n_bulk_error;
    logic [SEQ_W-1:0] r_last_seq, n_last_seq;

    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic [2:0]        r_out_result;
    logic [DATA_W-1:0] r_out_rdata;
    logic [SEQ_W-1:0]  r_out_seq;

    logic              w_req_fire;
    logic [AW-1:0]     w_rd_addr;
    logic [15:0]       w_addr_full;
    logic              w_adv;
    logic              w_step;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [DATA_W-1:0] w_mem_wdata;

    logic              x_slot_ok;
    logic [CFG_DATA_W-1:0] x_desc;
    logic [1:0]        x_type;
    logic [1:0]        x_perm;
    logic [SIZE_W-1:0] x_size;
    logic [SIZE_W-1:0] x_byte_off;
    logic [SIZE_W-1:0] x_remain;
    logic [2:0]        x_nbytes;
    logic [DATA_W-1:0] x_mask;
    logic [2:0]        x_res;
    logic              x_off_word_ok;

    logic              d_rejected;
    logic              d_xfer;
    logic [2:0]        d_res;
    logic              d_load;
    logic [1:0]        d_kind;
    logic [2:0]        d_result;
    logic [DATA_W-1:0] d_rdata;
    logic [SEQ_W-1:0]  d_seq;
    logic              d_wr_mem;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_clearing && (r_state == S_IDLE);
    assign w_req_fire  = i_req.valid && i_req.ready;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.response_kind = r_out_kind;
    assign o_rsp.result        = r_out_result;
    assign o_rsp.rd_word       = r_out_rdata;
    assign o_rsp.seq_number    = r_out_seq;

    always_comb begin
        w_addr_full = 16'(i_req.page) * 16'(PAGE_WORDS) + 16'(i_req.offset);
        if ((32'(i_req.page) < 32'(PAGE_SLOTS)) && (32'(i_req.offset) < 32'(PAGE_WORDS))) begin
            w_rd_addr = w_addr_full[AW-1:0];
        end else begin
            w_rd_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_fire) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_fire) begin
            r_req.message_empty <= i_req.message_empty;
            r_req.length_ok     <= i_req.length_ok;
            r_req.is_write      <= i_req.is_write;
            r_req.bulk          <= i_req.bulk;
            r_req.bulk_last     <= i_req.bulk_last;
            r_req.multiword     <= i_req.multiword;
            r_req.req_mode      <= i_req.req_mode;
            r_req.page          <= i_req.page;
            r_req.offset        <= i_req.offset;
            r_req.seq_count     <= i_req.seq_count;
            r_req.write_data    <= i_req.write_data;
            r_addr              <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_mode  <= '0;
            r_page_count <= '0;
            for (int i = 0; i < DESC_REGS; i++) begin
                r_desc[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_CONTROL_MODE: r_ctrl_mode  <= i_cfg.data[1:0];
                REG_PAGE_COUNT:   r_page_count <= i_cfg.data[2:0];
                REG_PAGE_ZERO:    r_desc[0]    <= i_cfg.data;
                REG_PAGE_ONE:     r_desc[1]    <= i_cfg.data;
                REG_PAGE_TWO:     r_desc[2]    <= i_cfg.data;
                REG_PAGE_THREE:   r_desc[3]    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // page bounds, permission and byte-lane mask
    always_comb begin
        x_slot_ok = (r_req.page < PAGE_W'(r_page_count))
                 && (32'(r_req.page) < 32'(PAGE_SLOTS))
                 && (32'(r_req.page) < 32'(DESC_REGS));
        x_desc     = r_desc[r_req.page[1:0]];
        x_type     = x_desc[1:0];
        x_perm     = x_desc[3:2];
        x_size     = x_desc[14:4];
        x_byte_off = {1'b0, r_req.offset, 2'b00};
        x_remain   = x_size - x_byte_off;
        x_off_word_ok = 32'(r_req.offset) < 32'(PAGE_WORDS);
        x_nbytes   = 3'd4;
        x_res      = RES_OK;
        if (!x_slot_ok) begin
            x_res = RES_ADDR;
        end else if (x_type == PTYPE_WORD) begin
            if (!(SIZE_W'(r_req.offset) < x_size) || !x_off_word_ok) begin
                x_res = RES_ADDR;
            end
        end else if (x_type == PTYPE_BYTE) begin
            if (!(x_byte_off < x_size) || !x_off_word_ok) begin
                x_res = RES_ADDR;
            end
            if (x_remain < SIZE_W'(LANES)) begin
                x_nbytes = {1'b0, x_remain[1:0]};
            end
        end else begin
            x_res = RES_ADDR;
        end
        if (x_res == RES_OK) begin
            if (r_req.is_write) begin
                if (x_perm != PERM_RW && x_perm != PERM_WO) begin
                    x_res = RES_PERM;
                end
            end else begin
                if (x_perm != PERM_RW && x_perm != PERM_RO) begin
                    x_res = RES_PERM;
                end
            end
        end
        for (int i = 0; i < LANES; i++) begin
            x_mask[i*LANE_BITS +: LANE_BITS] = (3'(i) < x_nbytes) ? '1 : '0;
        end
    end

    // request checks and bulk sequencing
    always_comb begin
        n_in_bulk    = r_in_bulk;
        n_bulk_error = r_bulk_error;
        n_last_seq   = r_last_seq;
        d_res        = RES_MALFORMED;
        d_rejected   = 1'b1;
        d_xfer       = 1'b0;
        d_load       = 1'b0;
        d_kind       = KIND_WRITE;
        d_result     = RES_OK;
        d_rdata      = '0;
        d_seq        = '0;
        priority if (!r_req.length_ok) begin
            d_res = RES_MALFORMED;
        end else if (r_in_bulk && !r_req.bulk) begin
            d_res = RES_SEQ;
        end else if (r_req.multiword && r_req.bulk) begin
            d_res = RES_MALFORMED;
        end else if (r_req.bulk && !r_req.is_write) begin
            d_res = RES_MALFORMED;
        end else if (r_req.bulk_last && !r_req.bulk) begin
            d_res = RES_MALFORMED;
        end else if (r_req.req_mode != r_ctrl_mode) begin
            d_res = RES_MODE;
        end else begin
            d_rejected = 1'b0;
            if (r_req.bulk) begin
                if (!r_in_bulk) begin
                    if (r_req.seq_count != '0) begin
                        d_res      = RES_SEQ;
                        d_rejected = 1'b1;
                    end else begin
                        n_in_bulk    = 1'b1;
                        n_bulk_error = '0;
                        n_last_seq   = '0;
                    end
                end else if (r_bulk_error == '0) begin
                    n_last_seq = r_last_seq + 1'b1;
                    if (r_req.seq_count != n_last_seq) begin
                        d_res      = RES_SEQ;
                        d_rejected = 1'b1;
                    end
                end
            end
            if (!d_rejected && (!n_in_bulk || n_bulk_error == '0)) begin
                d_xfer = 1'b1;
                d_res  = x_res;
            end
        end
        if (r_req.bulk) begin
            if (r_req.bulk_last) begin
                d_load    = 1'b1;
                d_kind    = KIND_BULK;
                d_result  = (n_bulk_error != '0) ? n_bulk_error : d_res;
                d_seq     = n_last_seq;
                n_in_bulk = 1'b0;
            end else if (n_bulk_error == '0) begin
                n_bulk_error = d_res;
            end
        end else begin
            d_load   = 1'b1;
            d_kind   = r_req.is_write ? KIND_WRITE : KIND_READ;
            d_result = d_res;
            if (!r_req.is_write && d_xfer && x_res == RES_OK) begin
                d_rdata = r_rdata & x_mask;
            end
        end
        d_wr_mem = d_xfer && (x_res == RES_OK) && r_req.is_write;
    end

    assign w_adv  = !r_out_valid || o_rsp.ready;
    assign w_step = (r_state == S_EXEC) && w_adv && !r_req.message_empty;

    always_comb begin
        if (r_clearing) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_addr;
            w_mem_wdata = '0;
        end else begin
            w_mem_we    = w_step && d_wr_mem;
            w_mem_waddr = r_addr;
            w_mem_wdata = (r_rdata & ~x_mask) | (r_req.write_data & x_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_adv || r_req.message_empty) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_bulk    <= 1'b0;
            r_bulk_error <= '0;
            r_last_seq   <= '0;
        end else if (w_step) begin
            r_in_bulk    <= n_in_bulk;
            r_bulk_error <= n_bulk_error;
            r_last_seq   <= n_last_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && d_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && d_load) begin
            r_out_kind   <= d_kind;
            r_out_result <= d_result;
            r_out_rdata  <= d_rdata;
            r_out_seq    <= d_seq;
        end
    end

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_req.ready)
        else $error("request accepted during clearing pass");

    a_accept_enters_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_fire |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execution");

    a_no_mem_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_clearing && r_state == S_IDLE) |-> !w_mem_we)
        else $error("memory written with no request in flight");

    a_bulk_closed_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_req.bulk && r_req.bulk_last) |=> !r_in_bulk)
        else $error("bulk still open after bulk end");

    a_rdata_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != KIND_READ) |-> (r_out_rdata == '0))
        else $error("read data in a non-read response");

endmodule
